// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check, switched off while reset is asserted
`define CLSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds through reset
`define CLSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define CLSL_ASSERT(lbl, clk, rst_n, prop)
`define CLSL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/clsl_pkg.sv -----
// ----------------------------------------------------------------------------
// clsl_pkg
// Request codes, fixed field widths and the statistics update bundle for
// the cache line state / LRU block.
// ----------------------------------------------------------------------------
package clsl_pkg;

    // fixed field widths
    localparam int REQ_W    = 3;
    localparam int LINE_W   = 8;
    localparam int END_W    = 9;
    localparam int VICTIM_W = 8;
    localparam int COUNT_W  = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FILL  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TOUCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DIRTY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PICK  = 3'd4;

    // statistics update strobes from the sequencer
    typedef struct packed {
        logic miss;
        logic hit;
        logic wb;
    } t_stat_upd;

endpackage

// ----- src/clsl_line_mem.sv -----
// ----------------------------------------------------------------------------
// clsl_line_mem
// Per-line state store {valid, dirty, stamp}: one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module clsl_line_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 34
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/clsl_stats.sv -----
// ----------------------------------------------------------------------------
// clsl_stats
// Saturating miss, hit and writeback counters and the global use clock
// that supplies line stamps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clsl_stats
    import clsl_pkg::*;
#(
    parameter int STAMP_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_stat_upd             i_upd,
    output logic [COUNT_W-1:0]    o_miss,
    output logic [COUNT_W-1:0]    o_hit,
    output logic [COUNT_W-1:0]    o_wb,
    output logic [STAMP_BITS-1:0] o_use_clock
);

    logic [COUNT_W-1:0]    r_miss;
    logic [COUNT_W-1:0]    r_hit;
    logic [COUNT_W-1:0]    r_wb;
    logic [STAMP_BITS-1:0] r_clock;

    // counters and clock stop at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss  <= '0;
            r_hit   <= '0;
            r_wb    <= '0;
            r_clock <= STAMP_BITS'(1);
        end else begin
            if (i_upd.miss && !(&r_miss)) begin
                r_miss <= r_miss + 1'b1;
            end
            if (i_upd.wb && !(&r_wb)) begin
                r_wb <= r_wb + 1'b1;
            end
            if (i_upd.hit) begin
                if (!(&r_hit)) begin
                    r_hit <= r_hit + 1'b1;
                end
                if (!(&r_clock)) begin
                    r_clock <= r_clock + 1'b1;
                end
            end
        end
    end

    assign o_miss      = r_miss;
    assign o_hit       = r_hit;
    assign o_wb        = r_wb;
    assign o_use_clock = r_clock;

    // assertions
    `CLSL_ASSERT(a_clock_nonzero, i_clk, i_rst_n, r_clock != '0)
    `CLSL_ASSERT(a_miss_monotonic, i_clk, i_rst_n, 1'b1 |=> r_miss >= $past(r_miss))
    `CLSL_ASSERT(a_hit_only_on_touch, i_clk, i_rst_n, !i_upd.hit |=> r_hit == $past(r_hit))

endmodule

// ----- src/cache_line_state_lru.sv -----
// ----------------------------------------------------------------------------
// cache_line_state_lru
// Line valid/dirty/stamp bookkeeping with LRU victim selection and
// saturating miss, hit and writeback statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_stall) and each
//   produces exactly one result transaction on the output channel
//   (o_out_valid / i_out_stall). One request is in flight at a time.
//   Fill, touch, mark dirty and query: the line state is read from the line
//   memory and, but for a query or a touch of an invalid line, modified and
//   written back; the request then passes through the line and done states.
//   Rejected requests skip the memory and go straight to the done state.
//   Victim pick: the window is scanned one line per cycle through the
//   memory read port, stopping at the first invalid line. In every case the
//   done state loads the result into the output register.
//   The next request is accepted in the cycle after the result is loaded,
//   even while that result is still stalled at the output.
//   After reset the block clears the line memory one entry per cycle with
//   o_in_stall high; then all lines are invalid, clean and stamped zero,
//   the use clock is one and the counters zero.
//   While i_out_stall is high the output holds and a finished result waits
//   internally until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cache_line_state_lru
    import clsl_pkg::*;
#(
    parameter int NUM_LINES  = 256,
    parameter int STAMP_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [LINE_W-1:0]   i_line_index,
    input  logic [LINE_W-1:0]   i_range_start,
    input  logic [END_W-1:0]    i_range_end,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_line_valid,
    output logic                o_line_dirty,
    output logic [VICTIM_W-1:0] o_victim_line,
    output logic [COUNT_W-1:0]  o_miss_total,
    output logic [COUNT_W-1:0]  o_hit_total,
    output logic [COUNT_W-1:0]  o_writeback_total,
    output logic                o_bad_request
);

    localparam int AW = $clog2(NUM_LINES);
    localparam int CW = (AW + 1 > END_W) ? AW + 1 : END_W;
    localparam int DW = STAMP_BITS + 2;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LINE  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [REQ_W-1:0]      r_req, n_req;
    logic [AW-1:0]         r_line, n_line;
    logic [CW-1:0]         r_end, n_end;
    logic [CW-1:0]         r_scan_idx, n_scan_idx;
    logic                  r_first, n_first;
    logic [AW-1:0]         r_best, n_best;
    logic                  r_best_dirty, n_best_dirty;
    logic [STAMP_BITS-1:0] r_oldest, n_oldest;
    // staged result
    logic                  r_res_lv, n_res_lv;
    logic                  r_res_ld, n_res_ld;
    logic [VICTIM_W-1:0]   r_res_victim, n_res_victim;
    logic                  r_res_bad, n_res_bad;
    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_lv, n_out_lv;
    logic                  r_out_ld, n_out_ld;
    logic [VICTIM_W-1:0]   r_out_victim, n_out_victim;
    logic [COUNT_W-1:0]    r_out_miss, n_out_miss;
    logic [COUNT_W-1:0]    r_out_hit, n_out_hit;
    logic [COUNT_W-1:0]    r_out_wb, n_out_wb;
    logic                  r_out_bad, n_out_bad;

    // memory and statistics hookup
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [DW-1:0]         mem_rd_data;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DW-1:0]         mem_wr_data;
    t_stat_upd             stat_upd;
    logic [COUNT_W-1:0]    stat_miss;
    logic [COUNT_W-1:0]    stat_hit;
    logic [COUNT_W-1:0]    stat_wb;
    logic [STAMP_BITS-1:0] use_clock;

    // decode of the word just read
    logic                  rd_v;
    logic                  rd_d;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [CW-1:0]         scan_next;
    logic                  take;
    logic                  line_bad;
    logic                  win_bad;
    logic                  nv;
    logic                  nd;
    logic [STAMP_BITS-1:0] nstamp;

    assign rd_v      = mem_rd_data[DW-1];
    assign rd_d      = mem_rd_data[DW-2];
    assign rd_stamp  = mem_rd_data[STAMP_BITS-1:0];
    assign scan_next = r_scan_idx + 1'b1;
    assign take      = r_first || (rd_stamp < r_oldest);
    assign line_bad  = CW'(i_line_index) >= CW'(NUM_LINES);
    assign win_bad   = (CW'(i_range_end) <= CW'(i_range_start))
                    || (CW'(i_range_end) > CW'(NUM_LINES));

    assign o_in_stall = (r_state != ST_IDLE);

    clsl_line_mem #(
        .DEPTH (NUM_LINES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    clsl_stats #(
        .STAMP_BITS (STAMP_BITS)
    ) u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (stat_upd),
        .o_miss      (stat_miss),
        .o_hit       (stat_hit),
        .o_wb        (stat_wb),
        .o_use_clock (use_clock)
    );

    // sequencer: clear, accept, read-modify-write or scan, stage result
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_req        = r_req;
        n_line       = r_line;
        n_end        = r_end;
        n_scan_idx   = r_scan_idx;
        n_first      = r_first;
        n_best       = r_best;
        n_best_dirty = r_best_dirty;
        n_oldest     = r_oldest;
        n_res_lv     = r_res_lv;
        n_res_ld     = r_res_ld;
        n_res_victim = r_res_victim;
        n_res_bad    = r_res_bad;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_lv     = r_out_lv;
        n_out_ld     = r_out_ld;
        n_out_victim = r_out_victim;
        n_out_miss   = r_out_miss;
        n_out_hit    = r_out_hit;
        n_out_wb     = r_out_wb;
        n_out_bad    = r_out_bad;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = AW'(i_line_index);
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_line;
        mem_wr_data  = '0;
        stat_upd     = '0;
        nv           = rd_v;
        nd           = rd_d;
        nstamp       = rd_stamp;

        case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NUM_LINES - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_req_type;
                    n_line       = AW'(i_line_index);
                    n_end        = CW'(i_range_end);
                    n_res_lv     = 1'b0;
                    n_res_ld     = 1'b0;
                    n_res_victim = '0;
                    n_res_bad    = 1'b0;
                    case (i_req_type)
                        REQ_FILL, REQ_TOUCH, REQ_DIRTY, REQ_QUERY: begin
                            if (line_bad) begin
                                n_res_bad = 1'b1;
                                n_state   = ST_DONE;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(i_line_index);
                                n_state     = ST_LINE;
                            end
                        end
                        REQ_PICK: begin
                            if (win_bad) begin
                                n_res_bad = 1'b1;
                                n_state   = ST_DONE;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(i_range_start);
                                n_scan_idx  = CW'(i_range_start);
                                n_first     = 1'b1;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_res_bad = 1'b1;
                            n_state   = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LINE: begin
                case (r_req)
                    REQ_FILL: begin
                        stat_upd.miss = 1'b1;
                        stat_upd.wb   = rd_v && rd_d;
                        nv            = 1'b1;
                        nd            = 1'b0;
                        mem_wr_en     = 1'b1;
                    end
                    REQ_TOUCH: begin
                        if (!rd_v) begin
                            n_res_bad = 1'b1;
                        end else begin
                            stat_upd.hit = 1'b1;
                            nstamp       = use_clock;
                            mem_wr_en    = 1'b1;
                        end
                    end
                    REQ_DIRTY: begin
                        nd        = 1'b1;
                        mem_wr_en = 1'b1;
                    end
                    default: begin
                        // query leaves the line alone
                    end
                endcase
                mem_wr_addr = r_line;
                mem_wr_data = {nv, nd, nstamp};
                n_res_lv    = nv;
                n_res_ld    = nd;
                n_state     = ST_DONE;
            end

            ST_SCAN: begin
                if (!rd_v) begin
                    // first invalid line wins outright
                    n_res_victim = VICTIM_W'(r_scan_idx);
                    n_res_lv     = 1'b0;
                    n_res_ld     = rd_d;
                    n_state      = ST_DONE;
                end else begin
                    if (take) begin
                        n_oldest     = rd_stamp;
                        n_best       = r_scan_idx[AW-1:0];
                        n_best_dirty = rd_d;
                    end
                    n_first = 1'b0;
                    if (scan_next == r_end) begin
                        n_res_victim = take ? VICTIM_W'(r_scan_idx) : VICTIM_W'(r_best);
                        n_res_lv     = 1'b1;
                        n_res_ld     = take ? rd_d : r_best_dirty;
                        n_state      = ST_DONE;
                    end else begin
                        n_scan_idx  = scan_next;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = scan_next[AW-1:0];
                    end
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_lv     = r_res_lv;
                    n_out_ld     = r_res_ld;
                    n_out_victim = r_res_victim;
                    n_out_miss   = stat_miss;
                    n_out_hit    = stat_hit;
                    n_out_wb     = stat_wb;
                    n_out_bad    = r_res_bad;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_line       <= n_line;
        r_end        <= n_end;
        r_scan_idx   <= n_scan_idx;
        r_best       <= n_best;
        r_best_dirty <= n_best_dirty;
        r_oldest     <= n_oldest;
        r_res_lv     <= n_res_lv;
        r_res_ld     <= n_res_ld;
        r_res_victim <= n_res_victim;
        r_res_bad    <= n_res_bad;
        r_out_lv     <= n_out_lv;
        r_out_ld     <= n_out_ld;
        r_out_victim <= n_out_victim;
        r_out_miss   <= n_out_miss;
        r_out_hit    <= n_out_hit;
        r_out_wb     <= n_out_wb;
        r_out_bad    <= n_out_bad;
    end

    assign o_out_valid       = r_out_valid;
    assign o_line_valid      = r_out_lv;
    assign o_line_dirty      = r_out_ld;
    assign o_victim_line     = r_out_victim;
    assign o_miss_total      = r_out_miss;
    assign o_hit_total       = r_out_hit;
    assign o_writeback_total = r_out_wb;
    assign o_bad_request     = r_out_bad;

    // assertions
    `CLSL_ASSERT(a_scan_in_window, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (r_scan_idx < r_end))
    `CLSL_ASSERT(a_line_in_range, i_clk, i_rst_n, (r_state == ST_LINE) |-> (CW'(r_line) < CW'(NUM_LINES)))
    `CLSL_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))

endmodule

// ----- bench/tb_cache_line_state_lru.sv -----
// ----------------------------------------------------------------------------
// tb_cache_line_state_lru
// Self-checking bench for the cache line state / LRU block. A queue of
// requests (directed corner cases, then a random mix aimed at a hot region
// of lines) is played through a valid/stall driver. A behavioural copy of
// the line state predicts each result transaction, and a monitor compares
// every field. Idling on both channels changes from phase to phase.
// ----------------------------------------------------------------------------
module tb_cache_line_state_lru;
    import clsl_pkg::*;

    localparam int LINES       = 256;
    localparam int RAND_ITEMS  = 550;
    localparam int HOT_LAST    = 31;
    localparam int DRAIN_WAIT  = LINES + 40;
    localparam int LIMIT_CYCLES = 1_000_000;

    // request codes that the block rejects as unknown
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = REQ_PICK + 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] win_lo;
        logic [END_W-1:0]  win_hi;
    } cache_req_t;

    typedef struct packed {
        logic                valid_bit;
        logic                dirty_bit;
        logic [VICTIM_W-1:0] victim;
        logic [COUNT_W-1:0]  misses;
        logic [COUNT_W-1:0]  hits;
        logic [COUNT_W-1:0]  writebacks;
        logic                bad;
    } line_report_t;

    // clock, reset and channel signals
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic out_stall = 1'b0;
    cache_req_t cur_req = '0;

    logic                req_stall;
    logic                out_valid;
    logic                got_valid_bit;
    logic                got_dirty_bit;
    logic [VICTIM_W-1:0] got_victim;
    logic [COUNT_W-1:0]  got_misses;
    logic [COUNT_W-1:0]  got_hits;
    logic [COUNT_W-1:0]  got_writebacks;
    logic                got_bad;

    // predicted line state
    logic               line_ok   [LINES];
    logic               line_dirty[LINES];
    logic [31:0]        line_stamp[LINES];
    logic [31:0]        use_clock;
    logic [COUNT_W-1:0] miss_count;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] wb_count;

    cache_req_t   req_backlog[$];
    line_report_t report_q[$];

    int accepted_count = 0;
    int total_items    = 1;
    int mismatch_count = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cache_line_state_lru uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_stall        (req_stall),
        .i_req_type        (cur_req.kind),
        .i_line_index      (cur_req.line),
        .i_range_start     (cur_req.win_lo),
        .i_range_end       (cur_req.win_hi),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_line_valid      (got_valid_bit),
        .o_line_dirty      (got_dirty_bit),
        .o_victim_line     (got_victim),
        .o_miss_total      (got_misses),
        .o_hit_total       (got_hits),
        .o_writeback_total (got_writebacks),
        .o_bad_request     (got_bad)
    );

    function automatic cache_req_t mk_req(logic [REQ_W-1:0] kind, int line, int lo, int hi);
        cache_req_t rq;
        rq.kind   = kind;
        rq.line   = line[LINE_W-1:0];
        rq.win_lo = lo[LINE_W-1:0];
        rq.win_hi = hi[END_W-1:0];
        return rq;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_bump(logic [COUNT_W-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // mostly lines of the hot region, so that windows there fill up
    function automatic int hot_line();
        return ($urandom_range(99) < 80) ? $urandom_range(HOT_LAST) : $urandom_range(LINES - 1);
    endfunction

    // idle pattern per phase: none, sender, receiver, both
    function automatic logic sender_rests();
        int phase;
        phase = accepted_count * 4 / total_items;
        if (phase == 1) return $urandom_range(99) < 72;
        if (phase == 3) return $urandom_range(99) < 28;
        return 1'b0;
    endfunction

    function automatic logic receiver_rests();
        int phase;
        phase = accepted_count * 4 / total_items;
        if (phase == 2) return $urandom_range(99) < 72;
        if (phase == 3) return $urandom_range(99) < 28;
        return 1'b0;
    endfunction

    // apply one request to the predicted state and queue its expected report
    task automatic update_line_state(input cache_req_t rq);
        line_report_t r;
        int           pos;
        int           pick;
        logic [31:0]  oldest;
        r = '0;
        // an 8-bit index always lies inside the 256 lines
        if (rq.kind <= REQ_QUERY) begin
            case (rq.kind)
                REQ_FILL: begin
                    miss_count = sat_bump(miss_count);
                    if (line_ok[rq.line] && line_dirty[rq.line])
                        wb_count = sat_bump(wb_count);
                    line_ok[rq.line]    = 1'b1;
                    line_dirty[rq.line] = 1'b0;
                end
                REQ_TOUCH: begin
                    if (!line_ok[rq.line]) begin
                        r.bad = 1'b1;
                    end else begin
                        hit_count = sat_bump(hit_count);
                        line_stamp[rq.line] = use_clock;
                        if (use_clock != '1)
                            use_clock = use_clock + 1'b1;
                    end
                end
                REQ_DIRTY: begin
                    line_dirty[rq.line] = 1'b1;
                end
                default: ;
            endcase
            r.valid_bit = line_ok[rq.line];
            r.dirty_bit = line_dirty[rq.line];
        end else if (rq.kind == REQ_PICK) begin
            if (rq.win_hi <= rq.win_lo || rq.win_hi > LINES) begin
                r.bad = 1'b1;
            end else begin
                // first invalid line wins, else oldest stamp, lowest index on ties
                pick   = rq.win_lo;
                oldest = line_stamp[rq.win_lo];
                for (pos = rq.win_lo; pos < rq.win_hi; pos++) begin
                    if (!line_ok[pos]) begin
                        pick = pos;
                        break;
                    end
                    if (line_stamp[pos] < oldest) begin
                        oldest = line_stamp[pos];
                        pick   = pos;
                    end
                end
                r.victim    = pick[VICTIM_W-1:0];
                r.valid_bit = line_ok[pick];
                r.dirty_bit = line_dirty[pick];
            end
        end else begin
            r.bad = 1'b1;
        end
        r.misses     = miss_count;
        r.hits       = hit_count;
        r.writebacks = wb_count;
        report_q.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // request driver: holds a stalled transaction, loads the next one otherwise
    always @(posedge clk) begin
        logic hold;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            hold = req_valid;
            if (req_valid && !req_stall) begin
                update_line_state(cur_req);
                accepted_count++;
                hold = 1'b0;
            end
            if (!hold) begin
                if (req_backlog.size() != 0 && !sender_rests()) begin
                    cur_req   <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk) begin
        line_report_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $time);
                    mismatch_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("line_valid", COUNT_W'(want.valid_bit),
                                COUNT_W'(got_valid_bit));
                    check_field("line_dirty", COUNT_W'(want.dirty_bit),
                                COUNT_W'(got_dirty_bit));
                    check_field("victim_line", COUNT_W'(want.victim), COUNT_W'(got_victim));
                    check_field("miss_total", want.misses, got_misses);
                    check_field("hit_total", want.hits, got_hits);
                    check_field("writeback_total", want.writebacks, got_writebacks);
                    check_field("bad_request", COUNT_W'(want.bad), COUNT_W'(got_bad));
                end
            end
            out_stall <= receiver_rests();
        end
    end

    // stimulus and end of run
    initial begin
        int idx;
        int roll;
        int lo;
        int hi;
        int k;

        for (idx = 0; idx < LINES; idx++) begin
            line_ok[idx]    = 1'b0;
            line_dirty[idx] = 1'b0;
            line_stamp[idx] = '0;
        end
        use_clock  = 32'd1;
        miss_count = '0;
        hit_count  = '0;
        wb_count   = '0;

        // directed corner cases
        req_backlog.push_back(mk_req(REQ_QUERY, 0, 0, 0));
        req_backlog.push_back(mk_req(REQ_QUERY, 255, 255, 511));
        req_backlog.push_back(mk_req(REQ_TOUCH, 7, 0, 0));       // invalid line
        req_backlog.push_back(mk_req(REQ_PICK, 0, 0, 256));      // whole cache, all invalid
        req_backlog.push_back(mk_req(REQ_DIRTY, 9, 0, 0));       // dirty while invalid
        req_backlog.push_back(mk_req(REQ_FILL, 9, 0, 0));        // clears dirty, no writeback
        for (idx = 0; idx < 4; idx++)
            req_backlog.push_back(mk_req(REQ_FILL, idx, 0, 0));
        req_backlog.push_back(mk_req(REQ_TOUCH, 2, 0, 0));
        req_backlog.push_back(mk_req(REQ_TOUCH, 0, 0, 0));
        req_backlog.push_back(mk_req(REQ_TOUCH, 3, 0, 0));
        req_backlog.push_back(mk_req(REQ_TOUCH, 1, 0, 0));
        req_backlog.push_back(mk_req(REQ_PICK, 0, 0, 4));        // all valid: oldest stamp
        req_backlog.push_back(mk_req(REQ_DIRTY, 2, 0, 0));
        req_backlog.push_back(mk_req(REQ_FILL, 2, 0, 0));        // dirty eviction
        req_backlog.push_back(mk_req(REQ_PICK, 0, 255, 256));    // one-line window
        req_backlog.push_back(mk_req(REQ_PICK, 0, 5, 5));        // empty window
        req_backlog.push_back(mk_req(REQ_PICK, 0, 200, 100));    // reversed window
        req_backlog.push_back(mk_req(REQ_PICK, 0, 255, 511));    // end past the last line
        for (k = REQ_UNKNOWN_FIRST; k <= REQ_UNKNOWN_LAST; k++)
            req_backlog.push_back(mk_req(k[REQ_W-1:0], 170, 85, 341));
        req_backlog.push_back(mk_req(REQ_FILL, 255, 0, 0));
        req_backlog.push_back(mk_req(REQ_TOUCH, 255, 0, 0));

        // random mix, mostly well-formed and focused on the hot region
        for (idx = 0; idx < RAND_ITEMS; idx++) begin
            roll = $urandom_range(99);
            lo   = $urandom_range(LINES - 1);
            if (roll < 22) begin
                req_backlog.push_back(mk_req(REQ_FILL, hot_line(), lo, $urandom_range(511)));
            end else if (roll < 50) begin
                req_backlog.push_back(mk_req(REQ_TOUCH, hot_line(), lo, $urandom_range(511)));
            end else if (roll < 62) begin
                req_backlog.push_back(mk_req(REQ_DIRTY, hot_line(), lo, $urandom_range(511)));
            end else if (roll < 70) begin
                req_backlog.push_back(mk_req(REQ_QUERY, hot_line(), lo, $urandom_range(511)));
            end else if (roll < 92) begin
                k = $urandom_range(99);
                if (k < 70) begin
                    lo = $urandom_range(HOT_LAST);
                    hi = lo + 1 + $urandom_range(HOT_LAST - lo);
                end else if (k < 90) begin
                    hi = lo + 1 + $urandom_range((LINES - 1 - lo < 15) ? LINES - 1 - lo : 15);
                end else begin
                    if (k < 95) lo = 0;
                    hi = LINES;
                end
                req_backlog.push_back(mk_req(REQ_PICK, $urandom_range(LINES - 1), lo, hi));
            end else if (roll < 97) begin
                // malformed window
                hi = ($urandom_range(1) != 0) ? $urandom_range(lo) : $urandom_range(511, LINES + 1);
                req_backlog.push_back(mk_req(REQ_PICK, $urandom_range(LINES - 1), lo, hi));
            end else begin
                req_backlog.push_back(
                    mk_req(REQ_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST)),
                           $urandom_range(LINES - 1), lo, $urandom_range(511)));
            end
        end
        total_items = req_backlog.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid) @(posedge clk);
        while (report_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(20 * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

endmodule
